FILE: hw/rtl/dsdl_pkg.sv
// Shared types, codes and defaults for the depth sorted draw list.
`timescale 1ns / 1ps
`default_nettype none

package dsdl_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // Width of every coordinate, rotation and scale field on the ports
    localparam int FIELD_W = 16;
    // Stored entry word: object, x, kind, rotation, scale
    localparam int DATA_W  = 8 + FIELD_W + 4 + FIELD_W + FIELD_W;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_EMIT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_ENTRY = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic [7:0]                object_id;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic [3:0]                kind;
        logic signed [FIELD_W-1:0] rotation;
        logic [FIELD_W-1:0]        scale;
        logic signed [FIELD_W-1:0] offset_x;
        logic signed [FIELD_W-1:0] offset_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [7:0]                object_id_res;
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic [3:0]                kind_res;
        logic signed [FIELD_W-1:0] rotation_res;
        logic [FIELD_W-1:0]        scale_res;
        logic                      last;
    } res_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       add_first;
        logic       ins_step;
        logic       place_zero;
        logic       emit_start;
        logic       emit_step;
        logic       clear;
        logic       count_inc;
        logic       res_load;
        logic [1:0] res_status;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic full;
        logic key_less;
        logic idx_zero;
        logic emit_end;
    } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/depth_sorted_draw_list_unit.sv
// Top level of the depth sorted draw list: controller and datapath.
//
//  channel   signals               direction  transfer
//  item      start, busy, item     in         start && !busy at a rising edge
//  result    strobe, result        out        strobe high for one cycle
//
//  Add: the insert walk reads one order word a cycle from the top of the
//  list down to the slot.
//  Emit: one entry a cycle through the order read, entry read and output
//  register. Clear, refused add and empty emit finish without leaving idle.
//  Reset empties the list; memories are not cleared. Results cannot be
//  stalled: each shows on the result port for one cycle after it is made.
`timescale 1ns / 1ps
`default_nettype none

module depth_sorted_draw_list_unit #(
    parameter int CAPACITY    = dsdl_pkg::CAPACITY_DEF,
    parameter int COORD_WIDTH = dsdl_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire dsdl_pkg::in_item_t  item,
    output dsdl_pkg::res_item_t      result,
    output logic                     strobe
);
    import dsdl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dsdl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dsdl_datapath #(
        .CAPACITY    (CAPACITY),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/dsdl_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dsdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dsdl_ctrl.sv
// Controller state machine for the depth sorted draw list.
`timescale 1ns / 1ps
`default_nettype none

module dsdl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    mode,
    input  wire dsdl_pkg::sts_t sts,
    output dsdl_pkg::cmd_t     cmd,
    output logic               busy
);
    import dsdl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_PLACE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (mode)
                        MODE_ADD:
                        begin
                            if (sts.full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.add_first = 1'b1;
                                state_next    = sts.count_zero ? S_PLACE : S_INSERT;
                            end
                        end
                        MODE_EMIT:
                        begin
                            if (sts.count_zero)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.emit_start = 1'b1;
                                state_next     = S_EMIT;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                        default:
                        begin
                            cmd.capture = 1'b0;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                cmd.ins_step = 1'b1;
                if (!sts.key_less)
                begin
                    cmd.count_inc  = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else if (sts.idx_zero)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place_zero = 1'b1;
                cmd.count_inc  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (sts.emit_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dsdl_datapath.sv
// Datapath: entry and order memories, insert walk, emit pipeline, result register.
`timescale 1ns / 1ps
`default_nettype none

module dsdl_datapath #(
    parameter int CAPACITY    = dsdl_pkg::CAPACITY_DEF,
    parameter int COORD_WIDTH = dsdl_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dsdl_pkg::cmd_t      cmd,
    output dsdl_pkg::sts_t           sts,
    input  wire dsdl_pkg::in_item_t  item,
    output dsdl_pkg::res_item_t      result,
    output logic                     strobe
);
    import dsdl_pkg::*;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ORD_W   = SLOT_W + FIELD_W;
    localparam int EXT_MSB = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH - 1 : FIELD_W - 1;

    logic [CNT_W-1:0]   count_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  iss_idx_reg;
    logic               iss_active_reg;
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [FIELD_W-1:0] y_reg;
    logic [FIELD_W-1:0] y_s2_reg;
    logic [FIELD_W-1:0] off_x_reg;
    logic [FIELD_W-1:0] off_y_reg;
    res_item_t          res_reg;
    res_item_t          res_next;
    logic               strobe_reg;

    logic [SLOT_W-1:0]  slot_new;
    logic [SLOT_W-1:0]  last_idx;
    logic [SLOT_W-1:0]  iss_idx_inc;
    logic [ORD_W-1:0]   ord_wdata;
    logic [ORD_W-1:0]   ord_rdata;
    logic [SLOT_W-1:0]  ord_waddr;
    logic [SLOT_W-1:0]  ord_raddr;
    logic               ord_we;
    logic [DATA_W-1:0]  dat_wdata;
    logic [DATA_W-1:0]  dat_rdata;
    logic [FIELD_W-1:0] rd_key;
    logic               key_less;
    logic [FIELD_W-1:0] sum_x;
    logic [FIELD_W-1:0] sum_y;

    // Keep COORD_WIDTH bits of a sum and sign extend them to the field width
    function automatic logic [FIELD_W-1:0] wrap_coord(input logic [FIELD_W-1:0] s);
        logic [FIELD_W-1:0] r;
        for (int b = 0; b < FIELD_W; b++)
        begin
            r[b] = (b <= EXT_MSB) ? s[b] : s[EXT_MSB];
        end
        return r;
    endfunction

    assign slot_new    = count_reg[SLOT_W-1:0];
    assign last_idx    = SLOT_W'(count_reg - CNT_W'(1));
    assign iss_idx_inc = iss_idx_reg + SLOT_W'(1);
    assign rd_key      = ord_rdata[FIELD_W-1:0];
    assign key_less    = $signed(y_reg) < $signed(rd_key);

    assign dat_wdata = {item.object_id, item.pos_x, item.kind, item.rotation, item.scale};

    // Order word holds slot and sort key; a shift moves the word one place up
    always_comb
    begin
        ord_we    = cmd.ins_step | cmd.place_zero;
        ord_waddr = cmd.place_zero ? '0 : idx_reg + SLOT_W'(1);
        ord_wdata = (cmd.ins_step && key_less) ? ord_rdata : {slot_new, y_reg};
        if (cmd.add_first)
        begin
            ord_raddr = last_idx;
        end
        else if (cmd.ins_step)
        begin
            ord_raddr = idx_reg - SLOT_W'(1);
        end
        else if (cmd.emit_step)
        begin
            ord_raddr = iss_idx_inc;
        end
        else
        begin
            ord_raddr = '0;
        end
    end

    dsdl_ram #(
        .WIDTH (ORD_W),
        .DEPTH (CAPACITY)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    dsdl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.add_first),
        .waddr (slot_new),
        .wdata (dat_wdata),
        .raddr (ord_rdata[ORD_W-1:FIELD_W]),
        .rdata (dat_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            iss_active_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.emit_start)
            begin
                s1_valid_reg   <= 1'b1;
                s1_last_reg    <= (last_idx == '0);
                iss_active_reg <= (last_idx != '0);
                s2_valid_reg   <= 1'b0;
                s2_last_reg    <= 1'b0;
            end
            else if (cmd.emit_step)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_last_reg  <= s1_last_reg;
                if (iss_active_reg)
                begin
                    s1_valid_reg   <= 1'b1;
                    s1_last_reg    <= (iss_idx_inc == last_idx);
                    iss_active_reg <= (iss_idx_inc != last_idx);
                end
                else
                begin
                    s1_valid_reg <= 1'b0;
                    s1_last_reg  <= 1'b0;
                end
            end
            else
            begin
                s1_valid_reg <= 1'b0;
                s2_valid_reg <= 1'b0;
            end

            strobe_reg <= cmd.res_load | (cmd.emit_step & s2_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            y_reg     <= item.pos_y;
            off_x_reg <= item.offset_x;
            off_y_reg <= item.offset_y;
        end
        if (cmd.add_first)
        begin
            idx_reg <= last_idx;
        end
        else if (cmd.ins_step && key_less)
        begin
            idx_reg <= idx_reg - SLOT_W'(1);
        end
        if (cmd.emit_start)
        begin
            iss_idx_reg <= '0;
        end
        else if (cmd.emit_step && iss_active_reg)
        begin
            iss_idx_reg <= iss_idx_inc;
        end
        y_s2_reg <= rd_key;
        res_reg  <= res_next;
    end

    assign sum_x = dat_rdata[DATA_W-9 -: FIELD_W] + off_x_reg;
    assign sum_y = y_s2_reg + off_y_reg;

    always_comb
    begin
        res_next = '0;
        if (cmd.res_load)
        begin
            res_next.status = cmd.res_status;
            res_next.last   = 1'b1;
        end
        else
        begin
            res_next.status        = ST_ENTRY;
            res_next.object_id_res = dat_rdata[DATA_W-1 -: 8];
            res_next.out_x         = wrap_coord(sum_x);
            res_next.out_y         = wrap_coord(sum_y);
            res_next.kind_res      = dat_rdata[2*FIELD_W +: 4];
            res_next.rotation_res  = dat_rdata[FIELD_W +: FIELD_W];
            res_next.scale_res     = dat_rdata[FIELD_W-1:0];
            res_next.last          = s2_last_reg;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == CNT_W'(CAPACITY));
    assign sts.key_less   = key_less;
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.emit_end   = s2_valid_reg & s2_last_reg;

    assign result = res_reg;
    assign strobe = strobe_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.res_load && s2_valid_reg))
        else $error("simple result collides with emitted entry");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_step |-> (CNT_W'(idx_reg) < count_reg))
        else $error("insert walk outside the stored entries");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step && s2_valid_reg && s2_last_reg) |->
            (!iss_active_reg && !s1_valid_reg))
        else $error("emit pipeline holds items after the last");

    a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step && s2_valid_reg) |=> (strobe && result.status == ST_ENTRY))
        else $error("emitted entry lost");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the depth sorted draw list unit.
`timescale 1ns / 1ps

module tb_top;

    import dsdl_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int TARGET_ITEMS = 310;
    localparam int TAIL_QUIET = 40;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]         obj;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [3:0]         kind;
        logic signed [15:0] rot;
        logic [15:0]        scale;
    } sprite_t;

    class draw_list_scoreboard;
        sprite_t   slot_mem[LIST_DEPTH];
        int        depth_order[LIST_DEPTH];
        int        entries;
        res_item_t due_results[$];
        int        mismatches;
        int        n_add, n_full, n_emit, n_empty, n_clear, n_streamed, peak;

        function new();
            entries = 0;
            mismatches = 0;
            n_add = 0;
            n_full = 0;
            n_emit = 0;
            n_empty = 0;
            n_clear = 0;
            n_streamed = 0;
            peak = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch(name, got, want);
        endtask

        function res_item_t status_only(logic [1:0] st);
            res_item_t r;
            r = '0;
            r.status = st;
            r.last = 1'b1;
            return r;
        endfunction

        // Update the list copy and queue the results one accepted item causes
        function void note_item(in_item_t it);
            int        pos;
            res_item_t r;
            sprite_t   s;
            case (it.mode)
                MODE_ADD:
                begin
                    if (entries >= LIST_DEPTH)
                    begin
                        n_full++;
                        due_results.push_back(status_only(ST_FULL));
                    end
                    else
                    begin
                        slot_mem[entries] = '{it.object_id, it.pos_x, it.pos_y, it.kind,
                                              it.rotation, it.scale};
                        // insert ahead of the first strictly deeper entry
                        pos = entries;
                        for (int i = 0; i < entries; i++)
                        begin
                            if ($signed(it.pos_y) < $signed(slot_mem[depth_order[i]].y))
                            begin
                                pos = i;
                                break;
                            end
                        end
                        for (int i = entries; i > pos; i--)
                            depth_order[i] = depth_order[i - 1];
                        depth_order[pos] = entries;
                        entries++;
                        if (entries > peak)
                            peak = entries;
                        n_add++;
                        due_results.push_back(status_only(ST_OK));
                    end
                end
                MODE_EMIT:
                begin
                    n_emit++;
                    if (entries == 0)
                    begin
                        n_empty++;
                        due_results.push_back(status_only(ST_EMPTY));
                    end
                    else
                    begin
                        for (int i = 0; i < entries; i++)
                        begin
                            s = slot_mem[depth_order[i]];
                            r = '0;
                            r.status = ST_ENTRY;
                            r.object_id_res = s.obj;
                            r.out_x = s.x + it.offset_x;
                            r.out_y = s.y + it.offset_y;
                            r.kind_res = s.kind;
                            r.rotation_res = s.rot;
                            r.scale_res = s.scale;
                            r.last = (i == entries - 1);
                            due_results.push_back(r);
                        end
                        n_streamed += entries;
                    end
                end
                MODE_CLEAR:
                begin
                    entries = 0;
                    n_clear++;
                    due_results.push_back(status_only(ST_OK));
                end
                default:
                    ;
            endcase
        endfunction

        task check_result(res_item_t got);
            res_item_t want;
            if (due_results.size() == 0)
            begin
                report_mismatch("result with nothing due, status", 32'(got.status), 0);
                return;
            end
            want = due_results.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("object_id_res", 32'(got.object_id_res), 32'(want.object_id_res));
            compare_field("out_x", 32'(got.out_x), 32'(want.out_x));
            compare_field("out_y", 32'(got.out_y), 32'(want.out_y));
            compare_field("kind_res", 32'(got.kind_res), 32'(want.kind_res));
            compare_field("rotation_res", 32'(got.rotation_res), 32'(want.rotation_res));
            compare_field("scale_res", 32'(got.scale_res), 32'(want.scale_res));
            compare_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    res_item_t result;
    logic      strobe;

    draw_list_scoreboard sb;
    int issued;
    bit quiet;

    depth_sorted_draw_list_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe === 1'b1)
            sb.check_result(result);
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function in_item_t random_bits();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // Favor a few nearby depths so ties show up often
    function logic signed [15:0] pick_depth();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3, 4, 5: return 16'($urandom_range(0, 6) - 3);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function logic signed [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 16'sh0000;
            1: return 16'sh7fff;
            2: return 16'sh8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function in_item_t make_add(logic [7:0] obj, logic [15:0] x, logic [15:0] y,
                                logic [3:0] kind, logic [15:0] rot, logic [15:0] scale);
        in_item_t it;
        it = random_bits();
        it.mode = MODE_ADD;
        it.object_id = obj;
        it.pos_x = x;
        it.pos_y = y;
        it.kind = kind;
        it.rotation = rot;
        it.scale = scale;
        return it;
    endfunction

    function in_item_t make_cmd(logic [1:0] mode, logic [15:0] off_x, logic [15:0] off_y);
        in_item_t it;
        it = random_bits();
        it.mode = mode;
        it.offset_x = off_x;
        it.offset_y = off_y;
        return it;
    endfunction

    // Hold start and the item until the block takes it
    task send_item(in_item_t it);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_item(it);
        if (it.mode != MODE_UNUSED)
            issued++;
    endtask

    task idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 6));
    endtask

    task wait_results_done();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.due_results.size() != 0);
    endtask

    initial
    begin
        in_item_t directed_q[$];
        in_item_t it;
        int episode;
        int burst;
        int settle;

        sb = new();
        issued = 0;
        quiet = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, field extremes, depth ties, offset wrap, unused mode
        directed_q.push_back(make_cmd(MODE_EMIT, 16'h0000, 16'h0000));
        directed_q.push_back(make_add(8'h00, 16'h7fff, 16'h7fff, 4'h0, 16'h8000, 16'h0000));
        directed_q.push_back(make_add(8'hff, 16'h8000, 16'h8000, 4'hf, 16'h7fff, 16'hffff));
        directed_q.push_back(make_add(8'h11, 16'h0000, 16'h0000, 4'h5, 16'h0000, 16'h1000));
        directed_q.push_back(make_add(8'h22, 16'hffff, 16'h0000, 4'ha, 16'hffff, 16'h8000));
        directed_q.push_back(make_add(8'h33, 16'h1234, 16'h0000, 4'h3, 16'h4321, 16'h7fff));
        directed_q.push_back(make_add(8'h44, 16'h0001, 16'h7fff, 4'hc, 16'h0001, 16'h0001));
        directed_q.push_back(make_add(8'h55, 16'h8001, 16'h8000, 4'h9, 16'h8001, 16'hfffe));
        directed_q.push_back(make_add(8'h66, 16'h00f0, 16'h0010, 4'h6, 16'h00ff, 16'h2000));
        directed_q.push_back(make_add(8'h77, 16'h0f00, 16'hfff0, 4'h7, 16'hff00, 16'h0800));
        directed_q.push_back(make_cmd(MODE_EMIT, 16'h0000, 16'h0000));
        directed_q.push_back(make_cmd(MODE_EMIT, 16'h7fff, 16'h7fff));
        directed_q.push_back(make_cmd(MODE_EMIT, 16'h8000, 16'h8000));
        directed_q.push_back(make_cmd(MODE_UNUSED, 16'h1111, 16'h2222));
        directed_q.push_back(make_cmd(MODE_EMIT, 16'hffff, 16'h0001));
        directed_q.push_back(make_cmd(MODE_CLEAR, 16'h0000, 16'h0000));
        directed_q.push_back(make_cmd(MODE_EMIT, 16'h0000, 16'h0000));
        directed_q.push_back(make_cmd(MODE_CLEAR, 16'h0000, 16'h0000));
        directed_q.push_back(make_add(8'h5a, 16'h0100, 16'h0200, 4'h1, 16'h0300, 16'h1000));
        directed_q.push_back(make_cmd(MODE_EMIT, 16'h0010, 16'hfff0));
        foreach (directed_q[i])
        begin
            send_item(directed_q[i]);
            maybe_idle();
        end

        // random: bursts of mostly adds with emits and random items mixed in, then an emit and usually a clear
        episode = 0;
        while (issued < TARGET_ITEMS)
        begin
            if (episode == 0 || $urandom_range(0, 3) == 0)
                burst = $urandom_range(60, 72);
            else
                burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && issued < TARGET_ITEMS; k++)
            begin
                case (episode == 0 ? 0 : $urandom_range(0, 19))
                    13, 14, 15, 16:
                        it = make_cmd(MODE_EMIT, pick_offset(), pick_offset());
                    17:
                        it = random_bits();
                    default:
                        it = make_add(8'($urandom), 16'($urandom), pick_depth(),
                                      4'($urandom), 16'($urandom), 16'($urandom));
                endcase
                send_item(it);
                maybe_idle();
                quiet = (issued > TARGET_ITEMS - TAIL_QUIET);
            end
            send_item(make_cmd(MODE_EMIT, pick_offset(), pick_offset()));
            maybe_idle();
            // skip the clear now and then so the list fills across bursts
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(make_cmd(MODE_CLEAR, pick_offset(), pick_offset()));
                maybe_idle();
            end
            if (episode == 2)
                wait_results_done();
            quiet = (issued > TARGET_ITEMS - TAIL_QUIET);
            episode++;
        end

        start <= 1'b0;
        settle = 0;
        do
        begin
            @(posedge clk);
            settle++;
        end
        while (sb.due_results.size() != 0 && settle < 20000);
        repeat (80) @(posedge clk);
        if (sb.due_results.size() != 0)
            sb.report_mismatch("results never arrived, count", sb.due_results.size(), 0);

        $display("ran %0d commands: %0d adds stored, %0d refused on a full list, %0d clears",
                 issued, sb.n_add, sb.n_full, sb.n_clear);
        $display("%0d emits (%0d on an empty list) streamed %0d entries, longest list %0d",
                 sb.n_emit, sb.n_empty, sb.n_streamed, sb.peak);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
